>>> src/prl_pkg.sv
// Shared types, codes and field layout for the positional record list.
package prl_pkg;

  // Fixed field widths of the stream payload
  localparam int POS_W      = 6;
  localparam int KIND_W     = 3;
  localparam int STATUS_W   = 2;
  localparam int IN_DATA_W  = 264;
  localparam int OUT_DATA_W = 272;
  // Cell index width covers the largest supported list depth
  localparam int IDX_W      = 10;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_INSERT      = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE_AT   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE_NAME = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FIND_NAME   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FIND_ID     = 3'd4;
  localparam logic [KIND_W-1:0] KIND_READ_AT     = 3'd5;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_POS   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  // One stored record
  typedef struct packed {
    logic        [63:0] id;
    logic        [63:0] nh;
    logic        [63:0] nm;
    logic        [31:0] nl;
    logic signed [31:0] sc;
  } rec_t;

  // What every cell of the chain does this cycle
  typedef enum logic [1:0] {
    CM_HOLD,
    CM_ROTATE,
    CM_INSERT,
    CM_REMOVE
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t       mode;
    logic [IDX_W-1:0] idx;
  } cell_ctrl_t;

  // Key compare result at the head of the chain
  typedef struct packed {
    logic name_hit;
    logic id_hit;
  } match_t;

endpackage

>>> src/prl_match.sv
// String-style compare of the head record against the request key.
module prl_match
  import prl_pkg::*;
(
  input  rec_t   head_i,
  input  rec_t   key_i,
  output match_t match_o
);

  logic [159:0] a_name;
  logic [159:0] b_name;
  logic [19:0]  n_eq;
  logic [19:0]  n_zero;
  logic [19:0]  n_ok;
  logic [7:0]   i_eq;
  logic [7:0]   i_zero;
  logic [7:0]   i_ok;

  assign a_name = {head_i.nh, head_i.nm, head_i.nl};
  assign b_name = {key_i.nh, key_i.nm, key_i.nl};

  // Per byte: equal, or an earlier equal terminator already ended the string
  always_comb begin
    for (int k = 0; k < 20; k++) begin
      n_eq[k]   = a_name[159-8*k -: 8] == b_name[159-8*k -: 8];
      n_zero[k] = n_eq[k] && (a_name[159-8*k -: 8] == 8'd0);
    end
    for (int k = 0; k < 20; k++) begin
      n_ok[k] = n_eq[k] || (|(n_zero & ((20'd1 << k) - 20'd1)));
    end
    for (int k = 0; k < 8; k++) begin
      i_eq[k]   = head_i.id[63-8*k -: 8] == key_i.id[63-8*k -: 8];
      i_zero[k] = i_eq[k] && (head_i.id[63-8*k -: 8] == 8'd0);
    end
    for (int k = 0; k < 8; k++) begin
      i_ok[k] = i_eq[k] || (|(i_zero & ((8'd1 << k) - 8'd1)));
    end
  end

  assign match_o.name_hit = &n_ok;
  assign match_o.id_hit   = &i_ok;

endmodule

>>> src/prl_cell.sv
// One cell of the record chain: holds a record, loads from a neighbor or takes the new record.
module prl_cell
  import prl_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic       clk,
  input  cell_ctrl_t ctrl_i,
  input  rec_t       left_i,
  input  rec_t       right_i,
  input  rec_t       new_i,
  output rec_t       rec_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  rec_t rec_r;
  rec_t rec_nxt;

  // Rotate toward the head, open a gap for insert, close one on remove
  always_comb begin
    rec_nxt = rec_r;
    unique case (ctrl_i.mode)
      CM_HOLD:   rec_nxt = rec_r;
      CM_ROTATE: rec_nxt = right_i;
      CM_INSERT: begin
        if (MY_IDX > ctrl_i.idx) begin
          rec_nxt = left_i;
        end else if (MY_IDX == ctrl_i.idx) begin
          rec_nxt = new_i;
        end
      end
      CM_REMOVE: begin
        if (MY_IDX >= ctrl_i.idx) begin
          rec_nxt = right_i;
        end
      end
      default:   rec_nxt = rec_r;
    endcase
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  assign rec_o = rec_r;

endmodule

>>> src/positional_record_list_unit.sv
// Top level of the positional record list: control FSM over a ring of cells.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+------------------------------------------
//  in      | in  | in_tvalid/tready  | tuser kind, tdata position..score
//  out     | out | out_tvalid/tready | tuser status, tdata position..count, tlast
//
//  Insert, bad position, full and unknown kinds: S_DECODE registers the result
//  once the output is free, then returns to idle. Every other kind goes through
//  S_SCAN, which rotates the whole ring once, and S_FINISH, which registers the
//  final result; any wait on a stalled output delays the request further.
//  Reset clears the fill count and the control; cell contents are not reset.
//  A new request is taken in idle even while a result still waits.
module positional_record_list_unit
  import prl_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // fields from bit 0: position(6) student_id(64) name_hi(64) name_mid(64)
  //   name_lo(32) score(32), zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // fields from bit 0: kind(3)
  input  logic [KIND_W-1:0]     in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // fields from bit 0: entry_position(6) entry_id(64) entry_name_hi(64)
  //   entry_name_mid(64) entry_name_lo(32) entry_score(32) entry_count(6), pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  // fields from bit 0: status(2)
  output logic [STATUS_W-1:0]   out_tuser,
  output logic                  out_tlast
);

  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int IW  = $clog2(CAPACITY);
  localparam int PCW = ((CW > POS_W) ? CW : POS_W) + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t            state_r, state_nxt;
  logic [KIND_W-1:0] op_kind_r, op_kind_nxt;
  logic [POS_W-1:0]  op_pos_r, op_pos_nxt;
  rec_t              op_rec_r, op_rec_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [IW-1:0]     step_r, step_nxt;
  rec_t              pend_r, pend_nxt;
  logic [IW-1:0]     pend_idx_r, pend_idx_nxt;
  logic              pend_valid_r, pend_valid_nxt;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [POS_W-1:0]    out_pos_r;
  rec_t                out_rec_r;
  logic [POS_W-1:0]    out_count_r;
  logic                out_last_r;

  logic                emit;
  logic [STATUS_W-1:0] em_status;
  logic [POS_W-1:0]    em_pos;
  rec_t                em_rec;
  logic                em_last;

  cell_ctrl_t cell_ctrl;
  rec_t       cell_q [CAPACITY];
  match_t     head_match;

  logic           out_free;
  logic [PCW-1:0] pos_ext;
  logic [PCW-1:0] cnt_ext;
  logic [PCW-1:0] pend_pos;
  logic           ins_bad;
  logic           acc_bad;
  logic           list_full;
  logic           in_range;
  logic           is_find;
  logic           is_remove;
  logic           hit;
  logic           stall;

  // Ring of cells; cell 0 is the head seen by the comparator
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    prl_cell #(
      .IDX(g)
    ) u_cell (
      .clk     (clk),
      .ctrl_i  (cell_ctrl),
      .left_i  (cell_q[(g + CAPACITY - 1) % CAPACITY]),
      .right_i (cell_q[(g + 1) % CAPACITY]),
      .new_i   (op_rec_r),
      .rec_o   (cell_q[g])
    );
  end

  prl_match u_match (
    .head_i  (cell_q[0]),
    .key_i   (op_rec_r),
    .match_o (head_match)
  );

  // Checks and scan hit decode
  assign out_free  = !out_valid_r || out_tready;
  assign pos_ext   = PCW'(op_pos_r);
  assign cnt_ext   = PCW'(count_r);
  assign pend_pos  = PCW'(pend_idx_r) + PCW'(1);
  assign ins_bad   = (pos_ext == '0) || (pos_ext > cnt_ext + PCW'(1));
  assign acc_bad   = (pos_ext == '0) || (pos_ext > cnt_ext);
  assign list_full = count_r >= CW'(CAPACITY);
  assign in_range  = CW'(step_r) < count_r;
  assign is_find   = (op_kind_r == KIND_FIND_NAME) || (op_kind_r == KIND_FIND_ID);
  assign is_remove = (op_kind_r == KIND_REMOVE_AT) || (op_kind_r == KIND_REMOVE_NAME);

  always_comb begin
    unique case (op_kind_r)
      KIND_REMOVE_AT,
      KIND_READ_AT:     hit = (PCW'(step_r) + PCW'(1)) == pos_ext;
      KIND_REMOVE_NAME: hit = in_range && head_match.name_hit && !pend_valid_r;
      KIND_FIND_NAME:   hit = in_range && head_match.name_hit;
      KIND_FIND_ID:     hit = in_range && head_match.id_hit;
      default:          hit = 1'b0;
    endcase
  end

  // A find hit pushes out the previous hit, which must find the output free
  assign stall = hit && is_find && pend_valid_r && !out_free;

  // Request sequencing
  always_comb begin
    state_nxt      = state_r;
    op_kind_nxt    = op_kind_r;
    op_pos_nxt     = op_pos_r;
    op_rec_nxt     = op_rec_r;
    count_nxt      = count_r;
    step_nxt       = step_r;
    pend_nxt       = pend_r;
    pend_idx_nxt   = pend_idx_r;
    pend_valid_nxt = pend_valid_r;
    emit           = 1'b0;
    em_status      = ST_OK;
    em_pos         = '0;
    em_rec         = '0;
    em_last        = 1'b1;
    cell_ctrl      = '{mode: CM_HOLD, idx: '0};

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_kind_nxt   = in_tuser;
          op_pos_nxt    = in_tdata[5:0];
          op_rec_nxt.id = in_tdata[69:6];
          op_rec_nxt.nh = in_tdata[133:70];
          op_rec_nxt.nm = in_tdata[197:134];
          op_rec_nxt.nl = in_tdata[229:198];
          op_rec_nxt.sc = in_tdata[261:230];
          state_nxt     = S_DECODE;
        end
      end

      S_DECODE: begin
        unique case (op_kind_r)
          KIND_INSERT: begin
            if (out_free) begin
              emit      = 1'b1;
              state_nxt = S_IDLE;
              if (ins_bad) begin
                em_status = ST_BAD_POS;
              end else if (list_full) begin
                em_status = ST_FULL;
              end else begin
                cell_ctrl = '{mode: CM_INSERT, idx: IDX_W'(pos_ext - PCW'(1))};
                count_nxt = count_r + CW'(1);
                em_pos    = op_pos_r;
                em_rec    = op_rec_r;
              end
            end
          end
          KIND_REMOVE_AT,
          KIND_READ_AT: begin
            if (!acc_bad) begin
              step_nxt  = '0;
              state_nxt = S_SCAN;
            end else if (out_free) begin
              emit      = 1'b1;
              em_status = ST_BAD_POS;
              state_nxt = S_IDLE;
            end
          end
          KIND_REMOVE_NAME,
          KIND_FIND_NAME,
          KIND_FIND_ID: begin
            step_nxt  = '0;
            state_nxt = S_SCAN;
          end
          default: begin
            if (out_free) begin
              emit      = 1'b1;
              em_status = ST_BAD_POS;
              state_nxt = S_IDLE;
            end
          end
        endcase
      end

      S_SCAN: begin
        if (!stall) begin
          cell_ctrl = '{mode: CM_ROTATE, idx: '0};
          if (hit) begin
            if (is_find && pend_valid_r) begin
              emit    = 1'b1;
              em_pos  = pend_pos[POS_W-1:0];
              em_rec  = pend_r;
              em_last = 1'b0;
            end
            pend_nxt       = cell_q[0];
            pend_idx_nxt   = step_r;
            pend_valid_nxt = 1'b1;
          end
          if (step_r == IW'(CAPACITY - 1)) begin
            step_nxt  = '0;
            state_nxt = S_FINISH;
          end else begin
            step_nxt = step_r + IW'(1);
          end
        end
      end

      S_FINISH: begin
        if (out_free) begin
          emit           = 1'b1;
          state_nxt      = S_IDLE;
          pend_valid_nxt = 1'b0;
          if (pend_valid_r) begin
            em_pos = pend_pos[POS_W-1:0];
            em_rec = pend_r;
            if (is_remove) begin
              cell_ctrl = '{mode: CM_REMOVE, idx: IDX_W'(pend_idx_r)};
              count_nxt = count_r - CW'(1);
            end
          end else begin
            em_status = ST_NOT_FOUND;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // State and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      step_r       <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      step_r       <= step_nxt;
      pend_valid_r <= pend_valid_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    op_kind_r  <= op_kind_nxt;
    op_pos_r   <= op_pos_nxt;
    op_rec_r   <= op_rec_nxt;
    pend_r     <= pend_nxt;
    pend_idx_r <= pend_idx_nxt;
    if (emit) begin
      out_status_r <= em_status;
      out_pos_r    <= em_pos;
      out_rec_r    <= em_rec;
      out_count_r  <= POS_W'(count_nxt);
      out_last_r   <= em_last;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {4'd0, out_count_r, out_rec_r.sc, out_rec_r.nl, out_rec_r.nm,
                       out_rec_r.nh, out_rec_r.id, out_pos_r};

endmodule

>>> src/prl_checker.sv
// Port-level checks for the positional record list, bound to the top level.
module prl_checker
  import prl_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [STATUS_W-1:0]   out_tuser,
  input logic                  out_tlast
);

  // A failed request reports no entry and is always the final result
  a_fail_no_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ST_OK) |-> (out_tdata[261:0] == '0 && out_tlast))
    else $error("failed request carries an entry or is not last");

  // A good result always names a real position
  a_ok_position: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ST_OK && CAPACITY < 64) |-> (out_tdata[5:0] != 6'd0))
    else $error("good result with position zero");

  // Fill count never exceeds the list depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && CAPACITY < 64) |-> (out_tdata[267:262] <= 6'(CAPACITY)))
    else $error("entry count beyond capacity");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast)))
    else $error("result changed while stalled");

  // One request at a time: input closes right after a request is taken
  a_in_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input still open after a request was taken");

endmodule

bind positional_record_list_unit prl_checker #(
  .CAPACITY(CAPACITY)
) u_prl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

>>> verif/tb_positional_record_list_unit.sv
// Self-checking testbench for the positional record list: directed table, fill to capacity, then random traffic.
`timescale 1ns / 100ps

module tb_positional_record_list_unit;
  import prl_pkg::*;

  localparam int CAPACITY    = 32;
  localparam int POOL_SIZE   = 5;
  localparam int PHASE_ITEMS = 32;
  localparam int QUIET_LIMIT = 4000;
  localparam int TAIL_CYCLES = 2 * CAPACITY + 8;

  // Kinds the block does not define; both must answer bad_position
  localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;

  // Keys for the directed table
  localparam logic [63:0] Z64     = 64'h0;
  localparam logic [31:0] Z32     = 32'h0;
  localparam logic [63:0] ID_FF   = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ID_01   = {"ID01", 32'h0};
  localparam logic [63:0] ID_01T  = {"ID01", 8'h00, 24'hC3_5A_FF};
  localparam logic [63:0] NM_FF_H = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NM_FF_M = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [31:0] NM_FF_L = 32'hFFFF_FFFF;
  localparam logic [63:0] NM_AB_H = {"AB", 48'h0};
  // same string "AB" with junk after the terminator
  localparam logic [63:0] NM_ABT_H = {"AB", 8'h00, 40'hA5_5A_FF_01_80};
  localparam logic [63:0] NM_ABT_M = 64'hDEAD_BEEF_0102_0304;
  localparam logic [31:0] NM_ABT_L = 32'h7F80_C3FF;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  pos;
    rec_t              rec;
  } list_req_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    pos;
    rec_t                entry;
    logic [POS_W-1:0]    count;
    logic                last;
  } list_result_t;

  // One directed row; hand_exp rows carry their answer, the rest use the predictor
  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [POS_W-1:0]    pos;
    logic [63:0]         id;
    logic [63:0]         nh;
    logic [63:0]         nm;
    logic [31:0]         nl;
    logic [31:0]         sc;
    logic                hand_exp;
    logic [STATUS_W-1:0] exp_status;
    logic [POS_W-1:0]    exp_count;
  } directed_row_t;

  localparam int DIR_ROWS = 25;
  localparam directed_row_t DIRECTED_TAB [DIR_ROWS] = '{
    // empty list: every access misses
    '{KIND_READ_AT, 6'd1, Z64, Z64, Z64, Z32, Z32, 1'b1, ST_BAD_POS, 6'd0},
    '{KIND_REMOVE_AT, 6'd0, Z64, Z64, Z64, Z32, Z32, 1'b1, ST_BAD_POS, 6'd0},
    '{KIND_FIND_NAME, 6'd0, Z64, NM_AB_H, Z64, Z32, Z32, 1'b1, ST_NOT_FOUND, 6'd0},
    '{KIND_FIND_ID, 6'd0, ID_01, Z64, Z64, Z32, Z32, 1'b1, ST_NOT_FOUND, 6'd0},
    '{KIND_REMOVE_NAME, 6'd0, Z64, NM_AB_H, Z64, Z32, Z32, 1'b1, ST_NOT_FOUND, 6'd0},
    '{KIND_INSERT, 6'd0, Z64, Z64, Z64, Z32, Z32, 1'b1, ST_BAD_POS, 6'd0},
    '{KIND_INSERT, 6'd2, Z64, Z64, Z64, Z32, Z32, 1'b1, ST_BAD_POS, 6'd0},
    // extremes of payload: all-ones keys with the largest score, all-zero keys with the smallest
    '{KIND_INSERT, 6'd1, ID_FF, NM_FF_H, NM_FF_M, NM_FF_L, 32'h7FFF_FFFF, 1'b0, ST_OK, 6'd0},
    '{KIND_INSERT, 6'd1, Z64, Z64, Z64, Z32, 32'h8000_0000, 1'b0, ST_OK, 6'd0},
    // append at the tail, then insert in the middle
    '{KIND_INSERT, 6'd3, ID_01, NM_AB_H, Z64, Z32, 32'h0000_0180, 1'b0, ST_OK, 6'd0},
    '{KIND_INSERT, 6'd2, ID_01T, NM_ABT_H, NM_ABT_M, NM_ABT_L, 32'hFFFF_FF80, 1'b0, ST_OK,
      6'd0},
    // bytes past the terminator are ignored, so two hits each
    '{KIND_FIND_NAME, 6'd0, Z64, NM_AB_H, Z64, Z32, Z32, 1'b0, ST_OK, 6'd0},
    '{KIND_FIND_ID, 6'd0, ID_01, Z64, Z64, Z32, Z32, 1'b0, ST_OK, 6'd0},
    // unterminated name differing only in the last byte
    '{KIND_FIND_NAME, 6'd0, Z64, NM_FF_H, NM_FF_M, 32'hFFFF_FFFE, Z32, 1'b1, ST_NOT_FOUND,
      6'd4},
    '{KIND_FIND_NAME, 6'd0, Z64, NM_FF_H, NM_FF_M, NM_FF_L, Z32, 1'b0, ST_OK, 6'd0},
    '{KIND_FIND_ID, 6'd0, Z64, Z64, Z64, Z32, Z32, 1'b0, ST_OK, 6'd0},
    '{KIND_READ_AT, 6'd4, Z64, Z64, Z64, Z32, Z32, 1'b0, ST_OK, 6'd0},
    '{KIND_READ_AT, 6'd5, Z64, Z64, Z64, Z32, Z32, 1'b1, ST_BAD_POS, 6'd4},
    '{KIND_REMOVE_AT, 6'd63, Z64, Z64, Z64, Z32, Z32, 1'b1, ST_BAD_POS, 6'd4},
    '{KIND_SPARE_6, 6'd1, ID_FF, NM_FF_H, NM_FF_M, NM_FF_L, 32'hFFFF_FFFF, 1'b1, ST_BAD_POS,
      6'd4},
    '{KIND_SPARE_7, 6'd1, Z64, Z64, Z64, Z32, Z32, 1'b1, ST_BAD_POS, 6'd4},
    // removes shift the tail down
    '{KIND_REMOVE_NAME, 6'd0, Z64, NM_AB_H, Z64, Z32, Z32, 1'b0, ST_OK, 6'd0},
    '{KIND_REMOVE_AT, 6'd1, Z64, Z64, Z64, Z32, Z32, 1'b0, ST_OK, 6'd0},
    '{KIND_FIND_NAME, 6'd0, Z64, Z64, Z64, Z32, Z32, 1'b1, ST_NOT_FOUND, 6'd2},
    '{KIND_READ_AT, 6'd2, Z64, Z64, Z64, Z32, Z32, 1'b0, ST_OK, 6'd0}
  };

  // Idle mix per random phase: none, sender, receiver, both
  localparam int SEND_IDLE  [4] = '{0, 67, 0, 30};
  localparam int RECV_STALL [4] = '{0, 0, 67, 30};

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [KIND_W-1:0]     in_tuser;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]   out_tuser;
  logic                  out_tlast;

  // Predictor state
  rec_t         list_store [CAPACITY];
  int           list_len;
  list_result_t pending_results [$];

  logic [159:0] name_pool [POOL_SIZE];
  logic [63:0]  id_pool [POOL_SIZE];

  int send_idle_pct;
  int recv_stall_pct;
  int fail_count   = 0;
  int quiet_cycles = 0;

  positional_record_list_unit #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  // 8 ns clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // C-string compare over at most nbytes, keys left aligned
  function automatic bit keys_equal(logic [159:0] a, logic [159:0] b, int nbytes);
    logic [7:0] x;
    logic [7:0] y;
    for (int k = 0; k < nbytes; k++) begin
      x = a[159 - 8 * k -: 8];
      y = b[159 - 8 * k -: 8];
      if (x != y) return 1'b0;
      if (x == 8'h00) return 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic logic [159:0] name_key(rec_t r);
    return {r.nh, r.nm, r.nl};
  endfunction

  task automatic push_result(logic [STATUS_W-1:0] status, int pos, rec_t entry, logic last);
    list_result_t res;
    res.status = status;
    res.pos    = POS_W'(pos);
    res.entry  = entry;
    res.count  = POS_W'(list_len);
    res.last   = last;
    pending_results.push_back(res);
  endtask

  task automatic drop_entry(int idx);
    for (int i = idx; i + 1 < list_len; i++) list_store[i] = list_store[i + 1];
    list_len--;
  endtask

  // Apply one request to the local list and queue what the block must answer
  task automatic predict_list_op(list_req_t req);
    int   p;
    bit   found;
    bit   hit;
    rec_t hold;
    int   hit_idx [$];
    p = int'(req.pos);
    case (req.kind)
      KIND_INSERT: begin
        if (p < 1 || p > list_len + 1) begin
          push_result(ST_BAD_POS, 0, '0, 1'b1);
        end else if (list_len >= CAPACITY) begin
          push_result(ST_FULL, 0, '0, 1'b1);
        end else begin
          for (int i = list_len; i >= p; i--) list_store[i] = list_store[i - 1];
          list_store[p - 1] = req.rec;
          list_len++;
          push_result(ST_OK, p, req.rec, 1'b1);
        end
      end
      KIND_REMOVE_AT, KIND_READ_AT: begin
        if (p < 1 || p > list_len) begin
          push_result(ST_BAD_POS, 0, '0, 1'b1);
        end else begin
          hold = list_store[p - 1];
          if (req.kind == KIND_REMOVE_AT) drop_entry(p - 1);
          push_result(ST_OK, p, hold, 1'b1);
        end
      end
      KIND_REMOVE_NAME: begin
        found = 1'b0;
        for (int i = 0; i < list_len && !found; i++) begin
          if (keys_equal(name_key(list_store[i]), name_key(req.rec), 20)) begin
            hold = list_store[i];
            drop_entry(i);
            push_result(ST_OK, i + 1, hold, 1'b1);
            found = 1'b1;
          end
        end
        if (!found) push_result(ST_NOT_FOUND, 0, '0, 1'b1);
      end
      KIND_FIND_NAME, KIND_FIND_ID: begin
        for (int i = 0; i < list_len; i++) begin
          if (req.kind == KIND_FIND_NAME)
            hit = keys_equal(name_key(list_store[i]), name_key(req.rec), 20);
          else
            hit = keys_equal({list_store[i].id, 96'h0}, {req.rec.id, 96'h0}, 8);
          if (hit) hit_idx.push_back(i);
        end
        if (hit_idx.size() == 0) push_result(ST_NOT_FOUND, 0, '0, 1'b1);
        foreach (hit_idx[k])
          push_result(ST_OK, hit_idx[k] + 1, list_store[hit_idx[k]], k == hit_idx.size() - 1);
      end
      default: begin
        push_result(ST_BAD_POS, 0, '0, 1'b1);
      end
    endcase
  endtask

  // Random key of up to nbytes, left aligned, sometimes with junk past the terminator
  function automatic logic [159:0] random_key(int nbytes);
    logic [159:0] v;
    int           len;
    bit           junk;
    v    = '0;
    len  = $urandom_range(0, nbytes);
    junk = 1'($urandom_range(0, 1));
    for (int k = 0; k < nbytes; k++) begin
      if (k < len) v[159 - 8 * k -: 8] = 8'($urandom_range(1, 255));
      else if (k > len && junk) v[159 - 8 * k -: 8] = 8'($urandom_range(0, 255));
    end
    return v;
  endfunction

  task automatic build_pools();
    logic [159:0] v;
    for (int n = 0; n < POOL_SIZE; n++) begin
      name_pool[n] = random_key(20);
      v = random_key(8);
      id_pool[n] = v[159:96];
    end
  endtask

  // Request with id and name from the pools, so that searches hit
  function automatic list_req_t make_request(logic [KIND_W-1:0] kind, int pos);
    list_req_t    r;
    logic [159:0] nm;
    nm        = name_pool[$urandom_range(0, POOL_SIZE - 1)];
    r.kind    = kind;
    r.pos     = POS_W'(pos);
    r.rec.id  = id_pool[$urandom_range(0, POOL_SIZE - 1)];
    r.rec.nh  = nm[159:96];
    r.rec.nm  = nm[95:32];
    r.rec.nl  = nm[31:0];
    r.rec.sc  = $urandom;
    return r;
  endfunction

  // Mostly well-formed requests at valid positions, some noise
  function automatic list_req_t gen_request();
    int                roll;
    int                pos;
    list_req_t         r;
    logic [KIND_W-1:0] kind;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      r.kind = KIND_W'($urandom_range(0, 7));
      r.pos  = POS_W'($urandom_range(0, 63));
      r.rec  = {$urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom};
      return r;
    end
    roll = $urandom_range(0, 99);
    if (roll < 30)      kind = KIND_INSERT;
    else if (roll < 45) kind = KIND_REMOVE_AT;
    else if (roll < 55) kind = KIND_REMOVE_NAME;
    else if (roll < 75) kind = KIND_FIND_NAME;
    else if (roll < 90) kind = KIND_FIND_ID;
    else                kind = KIND_READ_AT;
    if (kind == KIND_INSERT) pos = $urandom_range(1, list_len + 1);
    else if (list_len == 0)  pos = 1;
    else                     pos = $urandom_range(1, list_len);
    if ($urandom_range(0, 9) == 0) pos = $urandom_range(0, 63);
    return make_request(kind, pos);
  endfunction

  // Drive one request from a falling edge; returns at the falling edge after acceptance
  task automatic send_request(list_req_t req, bit hand_exp,
                              logic [STATUS_W-1:0] exp_status, logic [POS_W-1:0] exp_count);
    list_result_t fixed_res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req.kind;
    in_tdata  <= {2'b00, req.rec.sc, req.rec.nl, req.rec.nm, req.rec.nh, req.rec.id, req.pos};
    do @(posedge clk); while (!in_tready);
    if (hand_exp) begin
      fixed_res.status = exp_status;
      fixed_res.pos    = '0;
      fixed_res.entry  = '0;
      fixed_res.count  = exp_count;
      fixed_res.last   = 1'b1;
      pending_results.push_back(fixed_res);
    end else begin
      predict_list_op(req);
    end
    @(negedge clk);
  endtask

  // Hold off new requests until every queued result has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  function automatic int field_diff(string field, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", field, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Receiver backpressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Result checker
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request pending: status %0d position %0d",
               out_tuser, out_tdata[5:0]);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        fail_count += field_diff("status", 64'(want.status), 64'(out_tuser));
        fail_count += field_diff("entry_position", 64'(want.pos), 64'(out_tdata[5:0]));
        fail_count += field_diff("entry_id", want.entry.id, out_tdata[69:6]);
        fail_count += field_diff("entry_name_hi", want.entry.nh, out_tdata[133:70]);
        fail_count += field_diff("entry_name_mid", want.entry.nm, out_tdata[197:134]);
        fail_count += field_diff("entry_name_lo", 64'(want.entry.nl),
                                 64'(out_tdata[229:198]));
        fail_count += field_diff("entry_score", 64'($unsigned(want.entry.sc)),
                                 64'(out_tdata[261:230]));
        fail_count += field_diff("entry_count", 64'(want.count), 64'(out_tdata[267:262]));
        fail_count += field_diff("last", 64'(want.last), 64'(out_tlast));
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Stimulus
  initial begin
    list_req_t req;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = '0;
    list_len       = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int r = 0; r < DIR_ROWS; r++) begin
      req.kind = DIRECTED_TAB[r].kind;
      req.pos  = DIRECTED_TAB[r].pos;
      req.rec  = '{DIRECTED_TAB[r].id, DIRECTED_TAB[r].nh, DIRECTED_TAB[r].nm,
                   DIRECTED_TAB[r].nl, DIRECTED_TAB[r].sc};
      send_request(req, DIRECTED_TAB[r].hand_exp, DIRECTED_TAB[r].exp_status,
                   DIRECTED_TAB[r].exp_count);
    end
    drain_results();

    // fill to capacity, then inserts into a full list; position is checked first
    send_idle_pct  = 67;
    recv_stall_pct = 0;
    build_pools();
    while (list_len < CAPACITY)
      send_request(make_request(KIND_INSERT, $urandom_range(1, list_len + 1)), 1'b0, ST_OK, '0);
    send_request(make_request(KIND_INSERT, CAPACITY + 1), 1'b0, ST_OK, '0);
    send_request(make_request(KIND_INSERT, $urandom_range(1, CAPACITY)), 1'b0, ST_OK, '0);
    send_request(make_request(KIND_INSERT, CAPACITY + 2), 1'b0, ST_OK, '0);
    drain_results();

    // random phases, one per idle mix
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = SEND_IDLE[ph];
      recv_stall_pct = RECV_STALL[ph];
      build_pools();
      for (int n = 0; n < PHASE_ITEMS; n++) send_request(gen_request(), 1'b0, ST_OK, '0);
      drain_results();
    end

    // catch stray results after the last expected one
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
